// ===== rtl/mpe_pkg.sv =====
// Shared types and constants for the Mandelbrot pixel escape-time block.
`default_nettype none

package mpe_pkg;

    localparam int COORD_W    = 32;                 // Q8.24 coordinate and origin registers
    localparam int STEP_W     = 31;                 // pixel_step register
    localparam int IDX_W      = 10;                 // column / row index
    localparam int OFFS_W     = IDX_W + STEP_W;     // index * step
    localparam int SUM_W      = OFFS_W + 2;         // origin + offset before saturation
    localparam int Z_W        = COORD_W + 2;        // iterate width, |z| stays below |c| + 4
    localparam int COLOR_W    = 8;
    localparam int ITER_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd2;

    localparam logic signed [COORD_W-1:0] ORIGIN_X_RST   = -32'sd335544320;
    localparam logic signed [COORD_W-1:0] ORIGIN_Y_RST   = -32'sd251658240;
    localparam logic [STEP_W-1:0]         PIXEL_STEP_RST = 31'd838861;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    // 255^4, full scale of the colour ramp
    localparam logic [31:0] COLOR_FULL4 = 32'd4228250625;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_ON  = 8'd64;

    typedef struct packed {
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [ITER_W-1:0]  iterations;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX,      // column * step
        ST_CY,      // form cx, row * step
        ST_CSET,    // form cy, seed z
        ST_MXX,     // x * x
        ST_MYY,     // y * y
        ST_MXY,     // x * y, escape test
        ST_UPD,     // z = z^2 + c
        ST_RHS,     // n * 255^4
        ST_KSQ,     // k^2
        ST_K4,      // k^4
        ST_KM,      // k^4 * MAX_ITER
        ST_KCMP,    // keep or drop trial bit
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/mpe_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module mpe_mul #(
    parameter int WIDTH = 34
) (
    input  wire logic                      clk,
    input  wire logic signed [WIDTH-1:0]   a,
    input  wire logic signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0]      prod
);

    logic signed [2*WIDTH-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_pixel_escape.sv =====
// Mandelbrot escape-time evaluator: one pixel in, iteration count and colour out.
//
// Each item (column, row) becomes c = origin + index * pixel_step in signed
// fixed point with FRAC_BITS fraction bits, saturated to 32 bits, and the block
// iterates z = z^2 + c from z = c until |z|^2 >= 4 or MAX_ITER iterations.
// All multiplications go through one registered multiplier, three products per
// iteration plus an update step. The colour index is found by an 8-step binary
// search on the same multiplier. pixel_stall is high while an item is in work;
// a finished result waits in the output register, so the next item is taken
// while it is still unread.
`default_nettype none

module mandelbrot_pixel_escape #(
    parameter int MAX_ITER  = 256,
    parameter int FRAC_BITS = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pixel_valid,
    output logic                                   pixel_stall,
    input  wire mpe_pkg::pixel_t                   pixel,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output mpe_pkg::result_t                       result,
    input  wire logic                              cfg_we,
    input  wire logic [mpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ZW = mpe_pkg::Z_W;
    localparam int PW = 2 * ZW;
    localparam int NW = $clog2(MAX_ITER + 1);
    localparam logic signed [PW-1:0] LIMIT = PW'(4) << FRAC_BITS;
    localparam logic [NW-1:0] N_MAX = NW'(MAX_ITER);

    function automatic logic signed [mpe_pkg::COORD_W-1:0] sat_coord(
        input logic signed [mpe_pkg::COORD_W-1:0] origin,
        input logic [mpe_pkg::OFFS_W-1:0]         offs
    );
        logic signed [mpe_pkg::SUM_W-1:0] sum;
        sum = mpe_pkg::SUM_W'(origin) + $signed({2'b00, offs});
        if (sum > mpe_pkg::SUM_W'(mpe_pkg::COORD_MAX))
            return mpe_pkg::COORD_MAX;
        else if (sum < mpe_pkg::SUM_W'(mpe_pkg::COORD_MIN))
            return mpe_pkg::COORD_MIN;
        else
            return mpe_pkg::COORD_W'(sum);
    endfunction

    // configuration
    logic signed [mpe_pkg::COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [mpe_pkg::STEP_W-1:0]         pixel_step_reg;

    // control
    mpe_pkg::state_t state_reg, state_next;
    logic            result_valid_reg, result_valid_next;

    // datapath
    logic [mpe_pkg::IDX_W-1:0]          column_reg, column_next;
    logic [mpe_pkg::IDX_W-1:0]          row_reg, row_next;
    logic signed [mpe_pkg::COORD_W-1:0] cx_reg, cx_next;
    logic signed [mpe_pkg::COORD_W-1:0] cy_reg, cy_next;
    logic signed [ZW-1:0]               x_reg, x_next;
    logic signed [ZW-1:0]               y_reg, y_next;
    logic signed [PW-1:0]               x2_reg, x2_next;
    logic signed [PW-1:0]               y2_reg, y2_next;
    logic signed [PW-1:0]               rhs_reg, rhs_next;
    logic [NW-1:0]                      n_reg, n_next;
    logic [mpe_pkg::COLOR_W-1:0]        k_reg, k_next;
    logic [mpe_pkg::COLOR_W-1:0]        bit_reg, bit_next;
    mpe_pkg::result_t                   result_reg, result_next;

    logic signed [ZW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [PW-1:0] cx_wide, cy_wide;
    logic                 escape;
    logic                 last_iter;
    logic                 out_free;
    logic [mpe_pkg::COLOR_W-1:0] k_try;

    mpe_mul #(
        .WIDTH (ZW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_sh   = prod >>> FRAC_BITS;
    assign cx_wide   = PW'(cx_reg);
    assign cy_wide   = PW'(cy_reg);
    assign escape    = (x2_reg + prod_sh) >= LIMIT;
    assign last_iter = (n_reg + NW'(1)) == N_MAX;
    assign out_free  = !result_valid_reg || !result_stall;
    assign k_try     = k_reg | bit_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpe_pkg::ST_IDLE: if (pixel_valid) state_next = mpe_pkg::ST_CX;
            mpe_pkg::ST_CX:   state_next = mpe_pkg::ST_CY;
            mpe_pkg::ST_CY:   state_next = mpe_pkg::ST_CSET;
            mpe_pkg::ST_CSET: state_next = mpe_pkg::ST_MXX;
            mpe_pkg::ST_MXX:  state_next = mpe_pkg::ST_MYY;
            mpe_pkg::ST_MYY:  state_next = mpe_pkg::ST_MXY;
            mpe_pkg::ST_MXY:  state_next = escape ? mpe_pkg::ST_RHS : mpe_pkg::ST_UPD;
            mpe_pkg::ST_UPD:  state_next = last_iter ? mpe_pkg::ST_FIN : mpe_pkg::ST_MXX;
            mpe_pkg::ST_RHS:  state_next = mpe_pkg::ST_KSQ;
            mpe_pkg::ST_KSQ:  state_next = mpe_pkg::ST_K4;
            mpe_pkg::ST_K4:   state_next = mpe_pkg::ST_KM;
            mpe_pkg::ST_KM:   state_next = mpe_pkg::ST_KCMP;
            mpe_pkg::ST_KCMP: state_next = bit_reg[0] ? mpe_pkg::ST_FIN : mpe_pkg::ST_KSQ;
            mpe_pkg::ST_FIN:  if (out_free) state_next = mpe_pkg::ST_IDLE;
            default:          state_next = mpe_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        column_next       = column_reg;
        row_next          = row_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        x2_next           = x2_reg;
        y2_next           = y2_reg;
        rhs_next          = rhs_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        bit_next          = bit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        mul_a             = x_reg;
        mul_b             = y_reg;
        case (state_reg)
            mpe_pkg::ST_IDLE:
            begin
                column_next = pixel.column;
                row_next    = pixel.row;
            end
            mpe_pkg::ST_CX:
            begin
                mul_a = ZW'(column_reg);
                mul_b = ZW'(pixel_step_reg);
            end
            mpe_pkg::ST_CY:
            begin
                cx_next = sat_coord(origin_x_reg, prod[mpe_pkg::OFFS_W-1:0]);
                mul_a   = ZW'(row_reg);
                mul_b   = ZW'(pixel_step_reg);
            end
            mpe_pkg::ST_CSET:
            begin
                cy_next = sat_coord(origin_y_reg, prod[mpe_pkg::OFFS_W-1:0]);
                x_next  = ZW'(cx_reg);
                y_next  = ZW'(cy_next);
                n_next  = '0;
            end
            mpe_pkg::ST_MXX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            mpe_pkg::ST_MYY:
            begin
                x2_next = prod_sh;
                mul_a   = y_reg;
                mul_b   = y_reg;
            end
            mpe_pkg::ST_MXY:
            begin
                y2_next = prod_sh;
                mul_a   = x_reg;
                mul_b   = y_reg;
            end
            mpe_pkg::ST_UPD:
            begin
                x_next = ZW'(x2_reg - y2_reg + cx_wide);
                y_next = ZW'((prod_sh <<< 1) + cy_wide);
                n_next = n_reg + NW'(1);
            end
            mpe_pkg::ST_RHS:
            begin
                mul_a    = ZW'(n_reg);
                mul_b    = ZW'(mpe_pkg::COLOR_FULL4);
                k_next   = '0;
                bit_next = {1'b1, {(mpe_pkg::COLOR_W-1){1'b0}}};
            end
            mpe_pkg::ST_KSQ:
            begin
                rhs_next = (bit_reg[mpe_pkg::COLOR_W-1]) ? prod : rhs_reg;
                mul_a    = ZW'(k_try);
                mul_b    = ZW'(k_try);
            end
            mpe_pkg::ST_K4:
            begin
                mul_a = prod[ZW-1:0];
                mul_b = prod[ZW-1:0];
            end
            mpe_pkg::ST_KM:
            begin
                mul_a = prod[ZW-1:0];
                mul_b = ZW'(MAX_ITER);
            end
            mpe_pkg::ST_KCMP:
            begin
                if (prod <= rhs_reg)
                    k_next = k_try;
                bit_next = bit_reg >> 1;
            end
            mpe_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.iterations = mpe_pkg::ITER_W'(n_reg);
                    if (n_reg == N_MAX)
                    begin
                        result_next.blue  = '0;
                        result_next.green = '0;
                        result_next.red   = '0;
                    end
                    else
                    begin
                        result_next.blue  = mpe_pkg::COLOR_MAX - k_reg;
                        result_next.green = k_reg[0] ? mpe_pkg::GREEN_ON : '0;
                        result_next.red   = k_reg;
                    end
                end
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mpe_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            origin_x_reg     <= mpe_pkg::ORIGIN_X_RST;
            origin_y_reg     <= mpe_pkg::ORIGIN_Y_RST;
            pixel_step_reg   <= mpe_pkg::PIXEL_STEP_RST;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mpe_pkg::CFG_ORIGIN_X:   origin_x_reg   <= $signed(cfg_data);
                    mpe_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= $signed(cfg_data);
                    mpe_pkg::CFG_PIXEL_STEP: pixel_step_reg <= cfg_data[mpe_pkg::STEP_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        column_reg <= column_next;
        row_reg    <= row_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        rhs_reg    <= rhs_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        result_reg <= result_next;
    end

    assign pixel_stall  = (state_reg != mpe_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== tb/mandelbrot_pixel_escape_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Mandelbrot escape-time pixel block.
module mandelbrot_pixel_escape_test;
    import mpe_pkg::*;

    localparam int MAX_ITER = 256;
    localparam int FRAC_BITS = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint ESCAPE_RADIUS2 = longint'(4) << FRAC_BITS;
    localparam int LONG_HOLD = 3000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int REPORT_LIMIT = 10;
    localparam longint TIMEOUT_NS = 64'd60_000_000;

    class escape_scoreboard;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [STEP_W-1:0] pixel_step;
        result_t expected_colours[$];
        int failures;

        function new();
            origin_x = ORIGIN_X_RST;
            origin_y = ORIGIN_Y_RST;
            pixel_step = PIXEL_STEP_RST;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X: origin_x = data;
                CFG_ORIGIN_Y: origin_y = data;
                CFG_PIXEL_STEP: pixel_step = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // origin + index * step, saturated to 32 bits
        function longint coord(logic signed [COORD_W-1:0] origin, logic [IDX_W-1:0] index);
            longint v;
            v = longint'(origin) + longint'(index) * longint'(pixel_step);
            if (v > longint'(COORD_MAX))
                v = longint'(COORD_MAX);
            if (v < longint'(COORD_MIN))
                v = longint'(COORD_MIN);
            return v;
        endfunction

        function result_t escape_colour(pixel_t p);
            longint cx, cy, x, y, x2, y2, xy;
            longint unsigned rhs;
            int n, k, c;
            result_t r;
            cx = coord(origin_x, p.column);
            cy = coord(origin_y, p.row);
            x = cx;
            y = cy;
            for (n = 0; n < MAX_ITER; n++)
            begin
                // >>> on signed values rounds toward minus infinity
                x2 = (x * x) >>> FRAC_BITS;
                y2 = (y * y) >>> FRAC_BITS;
                xy = (x * y) >>> FRAC_BITS;
                if (x2 + y2 >= ESCAPE_RADIUS2)
                    break;
                x = x2 - y2 + cx;
                y = xy + xy + cy;
            end
            r = '0;
            r.iterations = ITER_W'(n);
            if (n < MAX_ITER)
            begin
                // largest k with k^4 * MAX_ITER <= n * 255^4
                rhs = longint'(n) * COLOR_FULL4;
                k = 0;
                for (c = 1; c <= 255; c++)
                begin
                    if (longint'(c) * c * c * c * MAX_ITER > rhs)
                        break;
                    k = c;
                end
                r.blue = COLOR_MAX - COLOR_W'(k);
                r.green = k[0] ? GREEN_ON : '0;
                r.red = COLOR_W'(k);
            end
            return r;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ERROR: %s", $time, msg);
        endfunction

        function void note_pixel(pixel_t p);
            expected_colours.push_back(escape_colour(p));
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_colours.size() == 0)
            begin
                flag($sformatf("result with no item outstanding: b=%0d g=%0d r=%0d n=%0d",
                               got.blue, got.green, got.red, got.iterations));
                return;
            end
            want = expected_colours.pop_front();
            if (got.blue !== want.blue || got.green !== want.green ||
                got.red !== want.red || got.iterations !== want.iterations)
                flag($sformatf("expected b=%0d g=%0d r=%0d n=%0d, got b=%0d g=%0d r=%0d n=%0d",
                               want.blue, want.green, want.red, want.iterations,
                               got.blue, got.green, got.red, got.iterations));
        endfunction

        function void check_drained();
            if (expected_colours.size() != 0)
            begin
                flag($sformatf("%0d items never produced a result", expected_colours.size()));
                failures += expected_colours.size() - 1;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic pixel_valid;
    logic pixel_stall;
    pixel_t pixel;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    escape_scoreboard sb;

    mandelbrot_pixel_escape #(
        .MAX_ITER(MAX_ITER),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            sb.check_result(result);
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_pixel(int col, int row);
        pixel_t p;
        p.column = IDX_W'(col);
        p.row = IDX_W'(row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        pixel <= p;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall !== 1'b0)
            @(posedge clk);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pixel_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    // block must be idle; also pokes the unmapped index, which must change nothing
    task automatic set_view(logic [31:0] ox, logic [31:0] oy, logic [31:0] step);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_PIXEL_STEP, step);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
    endtask

    // mostly pixels inside the window of interest, the rest anywhere on screen
    task automatic run_phase(int count, int send_pct, int recv_pct,
                             int col_lo, int col_hi, int row_lo, int row_hi);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
        begin
            if ($urandom_range(99) < 80)
                send_pixel($urandom_range(col_hi, col_lo), $urandom_range(row_hi, row_lo));
            else
                send_pixel($urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset view: field extremes, alternating bits, set interior and boundary
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(0, 1023);
        send_pixel(1023, 0);
        send_pixel(341, 682);
        send_pixel(682, 341);
        send_pixel(400, 300);
        send_pixel(385, 302);
        send_pixel(360, 300);
        wait_drained();

        // most negative origins, widest step; top step bit must be dropped
        set_view(COORD_MIN, COORD_MIN, 32'hFFFF_FFFF);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(2, 2);
        send_pixel(3, 1023);
        send_pixel(1023, 3);
        wait_drained();

        set_view(COORD_MAX, COORD_MAX, '0);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        wait_drained();

        // c = 0 for every pixel: never escapes
        set_view('0, '0, '0);
        send_pixel(517, 3);
        wait_drained();

        set_view(ORIGIN_X_RST, ORIGIN_Y_RST, PIXEL_STEP_RST);
        hold_req = 1'b1;
        run_phase(150, 0, 0, 350, 420, 270, 330);
        wait_drained();

        // whole set in a 256 x 256 window
        set_view(-32'sd37748736, -32'sd25165824, 32'd196608);
        run_phase(120, 77, 0, 0, 255, 0, 255);
        wait_drained();
        run_phase(100, 77, 0, 0, 255, 0, 255);
        wait_drained();

        // close-up of the boundary, long iteration counts
        set_view(-32'sd12792627, 32'sd1468006, 32'd8192);
        run_phase(150, 0, 77, 0, 63, 0, 63);
        wait_drained();

        set_view($urandom_range(1 << 26) - (3 << 24), $urandom_range(1 << 26) - (2 << 24),
                 $urandom_range(65536, 4096));
        run_phase(150, 29, 29, 0, 255, 0, 255);
        wait_drained();

        set_view(-32'sd37748736, -32'sd25165824, 32'd196608);
        run_phase(180, 29, 29, 0, 255, 0, 255);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.check_drained();
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
